FILE: hdl/mtfr_pkg.sv
// Package for the move-to-front run decoder: widths, byte codes, opcodes,
// controller states and the command, status and result structs.
// No dependencies; every other file in hdl/ imports it.
package mtfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int RUN_W     = 17;
  localparam int DIGIT_W   = 5;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam logic [BYTE_W-1:0]  DIGIT_ONE     = 8'hFD;
  localparam logic [BYTE_W-1:0]  DIGIT_TWO     = 8'hFE;
  localparam logic [DIGIT_W-1:0] DIGIT_LAST    = 5'd31;
  // Past this position even a single-weight digit overflows the count width.
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_POS = 5'd16;

  typedef enum logic [2:0] {
    OP_START,
    OP_LOAD,
    OP_DIG_ONE,
    OP_DIG_TWO,
    OP_INDEX
  } op_t;

  typedef enum logic {
    ST_BODY,
    ST_HEADER
  } state_t;

  typedef struct packed {
    logic take;
    op_t  op;
    logic flush;
    logic push_a;
    logic push_b;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic is_one;
    logic is_two;
    logic hdr_last;
    logic pending_nz;
  } stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [RUN_W-1:0]  run_length;
    logic              end_of_block;
  } res_t;

endpackage

FILE: hdl/move_to_front_run_decoder.sv
// Move-to-front decoder with zero-run digits; top level of controller,
// datapath and result queue. A result enters the queue when its byte is accepted
// and reaches out_ in order. Throughput: one byte per cycle, set by the
// combinational list shift; input stalls only while the four-entry result queue
// lacks room for two results. Reset (rst_n low, synchronous) clears the list
// to zeros, all counters and the queue. Depends on mtfr_pkg and the hdl modules.
module move_to_front_run_decoder import mtfr_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_RUN       = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_block_start,
  input  logic              in_block_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_symbol,
  output logic [RUN_W-1:0]  out_run_length,
  output logic              out_end_of_block
);

  cmd_t  cmd;
  stat_t stat;
  res_t  res_a, res_b, head;
  logic  room;

  mtfr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_block_start (in_block_start),
    .in_block_end   (in_block_end),
    .room           (room),
    .stat           (stat),
    .in_ready       (in_ready),
    .cmd            (cmd)
  );

  mtfr_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_RUN       (MAX_RUN)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  mtfr_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (cmd.push_a),
    .push_b    (cmd.push_b),
    .res_a     (res_a),
    .res_b     (res_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .room      (room)
  );

  assign out_symbol       = head.symbol;
  assign out_run_length   = head.run_length;
  assign out_end_of_block = head.end_of_block;

  // Two results from one byte only when an index byte also ends the block.
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_a && cmd.push_b) |-> (cmd.op == OP_INDEX && in_block_end))
    else $error("two results pushed for a byte that is not an ending index");

  a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_a |-> stat.pending_nz)
    else $error("run result pushed with zero pending count");

  a_push_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_a || cmd.push_b) |-> (in_valid && in_ready))
    else $error("result pushed without an input transfer");

  a_flush_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_b |=> out_valid)
    else $error("flushed run not presented on the result channel");

endmodule

FILE: hdl/mtfr_ctrl.sv
// Controller for the move-to-front run decoder: tracks header versus body
// phase and issues one command per accepted byte. Depends on mtfr_pkg.
module mtfr_ctrl import mtfr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_block_start,
  input  logic  in_block_end,
  input  logic  room,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BODY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.take) begin
      case (cmd.op)
        OP_START: begin
          state_nxt = (!stat.byte_zero && !in_block_end) ? ST_HEADER : ST_BODY;
        end
        OP_LOAD: begin
          state_nxt = (stat.hdr_last || in_block_end) ? ST_BODY : ST_HEADER;
        end
        default: begin
          state_nxt = ST_BODY;
        end
      endcase
    end
  end

  always_comb begin
    in_ready = room;
    cmd.take = in_valid && room;
    cmd.flush = in_block_end;
    if (in_block_start) begin
      cmd.op = OP_START;
    end else if (state_r == ST_HEADER) begin
      cmd.op = OP_LOAD;
    end else if (stat.is_one) begin
      cmd.op = OP_DIG_ONE;
    end else if (stat.is_two) begin
      cmd.op = OP_DIG_TWO;
    end else begin
      cmd.op = OP_INDEX;
    end
    // A body byte always leaves a nonzero count, so a body block end always flushes.
    cmd.push_a = cmd.take && (cmd.op == OP_INDEX) && stat.pending_nz;
    cmd.push_b = cmd.take && in_block_end &&
                 (cmd.op == OP_INDEX || cmd.op == OP_DIG_ONE || cmd.op == OP_DIG_TWO);
  end

endmodule

FILE: hdl/mtfr_dpath.sv
// Datapath for the move-to-front run decoder: the symbol list as a row of
// shifting registers, header counters, pending run count and digit position.
// Depends on mtfr_pkg.
module mtfr_dpath import mtfr_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_RUN       = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  cmd_t              cmd,
  output stat_t             stat,
  output res_t              res_a,
  output res_t              res_b
);

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [BYTE_W:0]    ALPHA_LIM = (BYTE_W + 1)'(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [RUN_W-1:0]   RUN_MAX   = RUN_W'(MAX_RUN);

  logic [BYTE_W-1:0]  list_r   [ALPHABET_SIZE];
  logic [BYTE_W-1:0]  list_nxt [ALPHABET_SIZE];
  logic [BYTE_W-1:0]  hdr_rem_r, hdr_rem_nxt;
  logic [BYTE_W-1:0]  load_pos_r, load_pos_nxt;
  logic [RUN_W-1:0]   pending_r, pending_nxt;
  logic [DIGIT_W-1:0] digit_pos_r, digit_pos_nxt;

  logic [IDX_W-1:0]   idx;
  logic [BYTE_W-1:0]  chosen;
  logic               load_ok;
  logic [RUN_W:0]     addend;
  logic [RUN_W:0]     sum;
  logic [RUN_W-1:0]   dig_count;
  logic [DIGIT_W-1:0] dig_pos_inc;

  always_comb begin
    if ({1'b0, in_data_byte} >= ALPHA_LIM) begin
      idx = LAST_IDX;
    end else begin
      idx = in_data_byte[IDX_W-1:0];
    end
    chosen  = list_r[idx];
    load_ok = ({1'b0, load_pos_r} < ALPHA_LIM);
  end

  // Run digit: add weight << k, saturating at the maximum run.
  always_comb begin
    addend = (RUN_W + 1)'(1) << digit_pos_r;
    if (cmd.op == OP_DIG_TWO) begin
      addend = (RUN_W + 1)'(2) << digit_pos_r;
    end
    sum = {1'b0, pending_r} + addend;
    if (digit_pos_r > DIGIT_MAX_POS || sum > {1'b0, RUN_MAX}) begin
      dig_count = RUN_MAX;
    end else begin
      dig_count = sum[RUN_W-1:0];
    end
    dig_pos_inc = (digit_pos_r == DIGIT_LAST) ? digit_pos_r : digit_pos_r + 1'b1;
  end

  always_comb begin
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      list_nxt[j] = list_r[j];
      if (cmd.take && cmd.op == OP_LOAD) begin
        if (load_ok && BYTE_W'(j) == load_pos_r) begin
          list_nxt[j] = in_data_byte;
        end
      end else if (cmd.take && cmd.op == OP_INDEX) begin
        if (j == 0) begin
          list_nxt[j] = chosen;
        end else if (IDX_W'(j) <= idx) begin
          list_nxt[j] = list_r[j-1];
        end
      end
    end
  end

  always_comb begin
    hdr_rem_nxt   = hdr_rem_r;
    load_pos_nxt  = load_pos_r;
    pending_nxt   = pending_r;
    digit_pos_nxt = digit_pos_r;
    if (cmd.take) begin
      case (cmd.op)
        OP_START: begin
          hdr_rem_nxt   = in_data_byte;
          load_pos_nxt  = '0;
          pending_nxt   = '0;
          digit_pos_nxt = '0;
        end
        OP_LOAD: begin
          hdr_rem_nxt  = hdr_rem_r - 1'b1;
          load_pos_nxt = load_pos_r + 1'b1;
        end
        OP_DIG_ONE, OP_DIG_TWO: begin
          pending_nxt   = dig_count;
          digit_pos_nxt = dig_pos_inc;
        end
        OP_INDEX: begin
          pending_nxt   = RUN_W'(1);
          digit_pos_nxt = '0;
        end
        default: begin
          pending_nxt = pending_r;
        end
      endcase
      if (cmd.flush) begin
        pending_nxt   = '0;
        digit_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ALPHABET_SIZE; j++) begin
        list_r[j] <= '0;
      end
      hdr_rem_r   <= '0;
      load_pos_r  <= '0;
      pending_r   <= '0;
      digit_pos_r <= '0;
    end else begin
      for (int j = 0; j < ALPHABET_SIZE; j++) begin
        list_r[j] <= list_nxt[j];
      end
      hdr_rem_r   <= hdr_rem_nxt;
      load_pos_r  <= load_pos_nxt;
      pending_r   <= pending_nxt;
      digit_pos_r <= digit_pos_nxt;
    end
  end

  always_comb begin
    stat.byte_zero  = (in_data_byte == '0);
    stat.is_one     = (in_data_byte == DIGIT_ONE);
    stat.is_two     = (in_data_byte == DIGIT_TWO);
    stat.hdr_last   = (hdr_rem_r == BYTE_W'(1));
    stat.pending_nz = (pending_r != '0);

    // The run that an index byte closes uses the front entry before the move.
    res_a.symbol       = list_r[0];
    res_a.run_length   = pending_r;
    res_a.end_of_block = 1'b0;

    res_b.symbol       = (cmd.op == OP_INDEX) ? chosen : list_r[0];
    res_b.run_length   = (cmd.op == OP_INDEX) ? RUN_W'(1) : dig_count;
    res_b.end_of_block = 1'b1;
  end

endmodule

FILE: hdl/mtfr_res_fifo.sv
// Result queue of the move-to-front run decoder: takes up to two results in
// a cycle and hands them out in order over valid/ready. Depends on mtfr_pkg.
module mtfr_res_fifo import mtfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_a,
  input  logic push_b,
  input  res_t res_a,
  input  res_t res_b,
  output logic out_valid,
  input  logic out_ready,
  output res_t head,
  output logic room
);

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic [RES_PTR_W-1:0] wr_b;
  logic                 pop;

  always_comb begin
    out_valid  = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    // Room for the two results one byte can cause.
    room       = (count_r <= RES_CNT_W'(RES_DEPTH - 2));
    pop        = out_valid && out_ready;
    wr_b       = wr_ptr_r + RES_PTR_W'(push_a);
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_a) + RES_PTR_W'(push_b);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push_a) + RES_CNT_W'(push_b) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= res_a;
    end
    if (push_b) begin
      mem_r[wr_b] <= res_b;
    end
  end

endmodule

FILE: test/tb_move_to_front_run_decoder.sv
// Testbench for move_to_front_run_decoder: directed blocks, then random blocks
// under random sender gaps and receiver stalls, checked against a local predictor.
// Depends on mtfr_pkg and the RTL in hdl/.
`timescale 1ns / 100ps

module tb_move_to_front_run_decoder;
  import mtfr_pkg::*;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_RUN       = 65536;
  localparam int ITEM_TARGET   = 1050;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum {RX_OPEN, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_block_start = 1'b0;
  logic              in_block_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_symbol;
  logic [RUN_W-1:0]  out_run_length;
  logic              out_end_of_block;

  // Predictor state.
  logic [BYTE_W-1:0]  mtf_list [ALPHABET_SIZE];
  logic [8:0]         hdr_left;
  logic [7:0]         load_slot;
  logic [RUN_W-1:0]   run_count;
  logic [DIGIT_W-1:0] digit_k;
  logic               loading;
  res_t               expected_runs [$];

  int       error_count = 0;
  int       bytes_sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       hold_left = 0;
  int       rx_phase = 0;
  rx_mode_t rx_mode = RX_OPEN;
  bit       long_hold_req = 1'b0;

  move_to_front_run_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_block_start   (in_block_start),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_run_length   (out_run_length),
    .out_end_of_block (out_end_of_block)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_model();
    foreach (mtf_list[i]) mtf_list[i] = '0;
    hdr_left  = '0;
    load_slot = '0;
    run_count = '0;
    digit_k   = '0;
    loading   = 1'b0;
  endfunction

  function automatic void emit_run(input logic eob);
    res_t r;
    r.symbol       = mtf_list[0];
    r.run_length   = run_count;
    r.end_of_block = eob;
    expected_runs.push_back(r);
  endfunction

  function automatic void add_run_digit(input logic [1:0] weight);
    logic [63:0] sum;
    sum = 64'(run_count) + (64'(weight) << digit_k);
    if (sum > 64'(MAX_RUN)) sum = 64'(MAX_RUN);
    run_count = sum[RUN_W-1:0];
    if (digit_k < DIGIT_LAST) digit_k = digit_k + 1'b1;
  endfunction

  function automatic void bring_to_front(input logic [BYTE_W-1:0] b);
    int idx;
    logic [BYTE_W-1:0] chosen;
    idx = (int'(b) > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : int'(b);
    chosen = mtf_list[idx];
    for (int j = idx; j > 0; j--) mtf_list[j] = mtf_list[j-1];
    mtf_list[0] = chosen;
  endfunction

  // Updates the predictor for one accepted byte and queues the runs it releases.
  function automatic void predict_runs(input logic [BYTE_W-1:0] b, input logic s,
                                       input logic e);
    if (s) begin
      hdr_left  = {1'b0, b};
      load_slot = '0;
      run_count = '0;
      digit_k   = '0;
      loading   = (b != 0) && !e;
      if (e) hdr_left = '0;
    end else if (loading) begin
      if (int'(load_slot) < ALPHABET_SIZE) mtf_list[load_slot] = b;
      load_slot = load_slot + 1'b1;
      hdr_left  = hdr_left - 1'b1;
      if (hdr_left == 0) loading = 1'b0;
      if (e) begin
        hdr_left  = '0;
        loading   = 1'b0;
        run_count = '0;
        digit_k   = '0;
      end
    end else begin
      if (b == DIGIT_ONE) begin
        add_run_digit(2'd1);
      end else if (b == DIGIT_TWO) begin
        add_run_digit(2'd2);
      end else begin
        if (run_count != 0) emit_run(1'b0);
        bring_to_front(b);
        run_count = 1;
        digit_k   = '0;
      end
      if (e) begin
        if (run_count != 0) emit_run(1'b1);
        run_count = '0;
        digit_k   = '0;
      end
    end
  endfunction

  // Both channels are sampled here, at the rising edge.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected result: symbol %0h run_length %0d end_of_block %0b",
                 out_symbol, out_run_length, out_end_of_block);
          error_count++;
        end else begin
          want = expected_runs.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("symbol: expected %0h, actual %0h", want.symbol, out_symbol);
            error_count++;
          end
          if (out_run_length !== want.run_length) begin
            $error("run_length: expected %0d, actual %0d", want.run_length, out_run_length);
            error_count++;
          end
          if (out_end_of_block !== want.end_of_block) begin
            $error("end_of_block: expected %0b, actual %0b", want.end_of_block,
                   out_end_of_block);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_runs(in_data_byte, in_block_start, in_block_end);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: a random stall pattern, picked anew each time rx_phase wraps, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) long_hold_req = 1'b0;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase = (rx_phase + 1) % 64;
      case (rx_mode)
        RX_OPEN:          out_ready <= 1'b1;
        RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
        RX_THREE_OF_FOUR: out_ready <= (rx_phase[1:0] != 2'd3);
        default:          out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Returns right after the transfer edge; the next call drives at the next falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s = 1'b0,
                           input logic e = 1'b0);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_block_start <= s;
    in_block_end   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_for_results();
    go_quiet();
    while (expected_runs.size() != 0) @(negedge clk);
  endtask

  task automatic send_header(input int count);
    send_byte(8'(count), 1'b1, 1'b0);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_digits(input int count);
    repeat (count) send_byte($urandom_range(0, 1) ? DIGIT_TWO : DIGIT_ONE);
  endtask

  // Mostly digits and indexes near the loaded part of the list.
  task automatic send_body(input int len, input int idx_hi, input bit with_end);
    int r;
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 2) b = DIGIT_ONE;
      else if (r < 4) b = DIGIT_TWO;
      else if (r < 8) b = 8'($urandom_range(0, idx_hi));
      else b = 8'($urandom_range(0, 255));
      send_byte(b, 1'b0, with_end && (i == len - 1));
    end
  endtask

  task automatic test_no_block_start();
    send_byte(8'h00);
    send_byte(8'h07);
    send_byte(DIGIT_ONE, 1'b0, 1'b1);
    send_byte(8'h03);
    send_byte(8'h01, 1'b0, 1'b1);
  endtask

  task automatic test_basic_block();
    send_byte(8'd4, 1'b1, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(DIGIT_ONE);
    send_byte(DIGIT_TWO);
    send_byte(8'h03);
    send_byte(DIGIT_ONE);
    send_byte(DIGIT_TWO);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(DIGIT_ONE, 1'b0, 1'b1);
  endtask

  task automatic test_header_edges();
    // Zero header count, then an empty block, then a block that ends mid-header.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h02);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h03, 1'b1, 1'b0);
    send_byte(8'h81);
    send_byte(8'h42, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
  endtask

  task automatic test_restart_mid_block();
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h5A);
    send_byte(DIGIT_ONE);
    send_byte(DIGIT_TWO);
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_byte(8'h01, 1'b0, 1'b1);
  endtask

  task automatic test_long_runs();
    send_header(2);
    send_digits(0);
    repeat (17) send_byte(DIGIT_TWO);
    send_byte(8'h01);
    repeat (16) send_byte(DIGIT_ONE);
    send_byte(DIGIT_ONE);
    repeat (18) send_byte(DIGIT_ONE);
    send_byte(DIGIT_TWO, 1'b0, 1'b1);
  endtask

  task automatic test_full_list();
    send_header(255);
    send_byte(8'hFF);
    send_byte(8'hFC);
    send_byte(8'h80);
    send_body(10, 255, 1'b1);
  endtask

  task automatic test_backpressure();
    send_header(6);
    long_hold_req = 1'b1;
    send_body(40, 7, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_blocks();
    int kind;
    int hdr;
    int cnt;
    while (bytes_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      if (kind < 15) begin
        send_header(hdr);
        if ($urandom_range(0, 7) == 0) send_digits($urandom_range(10, 36));
        send_body($urandom_range(1, 24), hdr + 2, 1'b1);
      end else if (kind == 15) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end else if (kind == 16) begin
        cnt = $urandom_range(2, 10);
        send_byte(8'(cnt), 1'b1, 1'b0);
        repeat ($urandom_range(0, cnt - 2)) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else if (kind == 17) begin
        // Left open: the next block start drops the pending run.
        send_header(hdr);
        send_body($urandom_range(1, 12), hdr + 2, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                    ($urandom_range(0, 7) == 0));
      end
      if ($urandom_range(0, 24) == 0) wait_for_results();
    end
  endtask

  initial begin
    clear_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_block_start();
    test_basic_block();
    test_header_edges();
    test_restart_mid_block();
    wait_for_results();
    test_long_runs();
    test_full_list();
    test_backpressure();
    test_random_blocks();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
